[hw/rtl/cts_pkg.sv]
`timescale 1ns / 1ps

package cts_pkg;

  localparam int ARG_W    = 16;
  localparam int OUT_W    = 28;
  localparam int CNT_W    = 4;
  // term and sum widths cover the largest term count the block supports
  localparam int TERM_W   = 48;
  localparam int SUM_W    = 48;
  localparam int HALF_W   = TERM_W / 2;
  localparam int PROD_W   = HALF_W + ARG_W;
  localparam int FULL_W   = 64;
  localparam int X_FRAC   = 12;
  localparam int ONE_POS  = 32;
  localparam int OUT_SH   = 16;
  localparam int DVS_W    = 10;
  localparam int DIV_BITS = 8;
  localparam int DIV_CYC  = TERM_W / DIV_BITS;
  localparam int DC_W     = $clog2(DIV_CYC);

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};
  localparam logic [CNT_W-1:0] CNT_RESET = 4'd4;

  typedef struct packed {
    logic             load;
    logic             mul_lo;
    logic             mul_hi;
    logic             div_step;
    logic             acc;
    logic             out_load;
    logic [CNT_W-1:0] k;
  } cmd_t;

  // (2k-1)*(2k) for series index k
  function automatic logic [DVS_W-1:0] divisor_of(input logic [CNT_W-1:0] k);
    logic [DVS_W-1:0] d;
    case (k)
      4'd1:    d = 10'd2;
      4'd2:    d = 10'd12;
      4'd3:    d = 10'd30;
      4'd4:    d = 10'd56;
      4'd5:    d = 10'd90;
      4'd6:    d = 10'd132;
      4'd7:    d = 10'd182;
      4'd8:    d = 10'd240;
      4'd9:    d = 10'd306;
      4'd10:   d = 10'd380;
      4'd11:   d = 10'd462;
      4'd12:   d = 10'd552;
      default: d = 10'd1;
    endcase
    return d;
  endfunction

endpackage

[hw/rtl/cosh_taylor_series.sv]
`timescale 1ns / 1ps

// Hyperbolic cosine by truncated Taylor series: one Q3.12 argument in, one
// unsigned Q12.16 sum out (rounded, saturated with a flag). term_count (reset
// 4, clamped to MAX_TERMS) sets the highest index k summed. An item runs n
// terms, n being the clamped term count: each term takes two multiplies by
// |x| (low and high 24x16 partial products), a pass of an eight-bit-per-cycle
// divider by (2k-1)(2k), and an accumulate step. The result sits in an output
// register, so a new argument is taken while the previous result still waits;
// a finished sum is held in its last cycle until that register is free.
module cosh_taylor_series import cts_pkg::*; #(
  parameter int MAX_TERMS = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [ARG_W-1:0] in_arg_x,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [OUT_W-1:0]        out_cosh_value,
  output logic                    out_saturated,
  input  logic                    cfg_we,
  input  logic [CNT_W-1:0]        cfg_wdata
);

  cmd_t cmd;

  cts_ctrl #(
    .MAX_TERMS(MAX_TERMS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd)
  );

  cts_datapath u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .in_arg_x      (in_arg_x),
    .out_cosh_value(out_cosh_value),
    .out_saturated (out_saturated)
  );

endmodule

[hw/rtl/cts_ctrl.sv]
`timescale 1ns / 1ps

module cts_ctrl import cts_pkg::*; #(
  parameter int MAX_TERMS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output cmd_t             cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL_LO = 6'b000010,
    S_MUL_HI = 6'b000100,
    S_DIV    = 6'b001000,
    S_ACC    = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_TERMS);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_cfg_r, count_cfg_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  logic [DC_W-1:0]  dcnt_r, dcnt_nxt;
  logic             pass_r, pass_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] n_eff;
  logic             in_xfer;
  logic             out_free;

  assign n_eff    = (count_cfg_r > MAX_N) ? MAX_N : count_cfg_r;
  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    count_cfg_nxt = cfg_we ? cfg_wdata : count_cfg_r;
    k_nxt         = k_r;
    dcnt_nxt      = dcnt_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.k         = k_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd.load  = 1'b1;
          k_nxt     = CNT_W'(1);
          pass_nxt  = 1'b0;
          state_nxt = (n_eff == '0) ? S_DONE : S_MUL_LO;
        end
      end
      S_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        if (!pass_r) begin
          pass_nxt  = 1'b1;
          state_nxt = S_MUL_LO;
        end else begin
          pass_nxt  = 1'b0;
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DC_W'(1);
        if (dcnt_r == DC_W'(DIV_CYC - 1)) begin
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (k_r == n_eff) begin
          state_nxt = S_DONE;
        end else begin
          k_nxt     = k_r + CNT_W'(1);
          state_nxt = S_MUL_LO;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_cfg_r <= CNT_RESET;
      k_r         <= '0;
      dcnt_r      <= '0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_cfg_r <= count_cfg_nxt;
      k_r         <= k_nxt;
      dcnt_r      <= dcnt_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hw/rtl/cts_datapath.sv]
`timescale 1ns / 1ps

module cts_datapath import cts_pkg::*; (
  input  logic                    clk,
  input  cmd_t                    cmd,
  input  logic signed [ARG_W-1:0] in_arg_x,
  output logic [OUT_W-1:0]        out_cosh_value,
  output logic                    out_saturated
);

  logic [ARG_W-1:0]  mag_r, mag_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [PROD_W-1:0] plo_r, plo_nxt;
  logic [DVS_W-1:0]  rem_r, rem_nxt;
  logic [OUT_W-1:0]  value_r, value_nxt;
  logic              sat_r, sat_nxt;

  logic [PROD_W-1:0]       phi;
  logic [FULL_W-1:0]       full;
  logic [DVS_W-1:0]        dvs;
  logic [SUM_W:0]          rsum;
  logic [SUM_W-OUT_SH:0]   rounded;

  assign phi  = PROD_W'(term_r[TERM_W-1:HALF_W]) * PROD_W'(mag_r);
  assign full = {phi, {HALF_W{1'b0}}} + FULL_W'(plo_r);
  assign dvs  = divisor_of(cmd.k);
  assign rsum = {1'b0, sum_r} + (SUM_W+1)'(1 << (OUT_SH - 1));
  assign rounded = rsum[SUM_W:OUT_SH];

  always_comb begin
    logic [DVS_W:0]    r;
    logic [TERM_W-1:0] dv;
    mag_nxt   = mag_r;
    term_nxt  = term_r;
    sum_nxt   = sum_r;
    plo_nxt   = plo_r;
    rem_nxt   = rem_r;
    value_nxt = value_r;
    sat_nxt   = sat_r;
    r         = {1'b0, rem_r};
    dv        = term_r;
    if (cmd.load) begin
      // only even powers occur, so the sign drops out
      mag_nxt  = in_arg_x[ARG_W-1] ? ARG_W'(~in_arg_x + 1'b1) : ARG_W'(in_arg_x);
      term_nxt = TERM_W'(1) << ONE_POS;
      sum_nxt  = SUM_W'(1) << ONE_POS;
    end
    if (cmd.mul_lo) begin
      plo_nxt = PROD_W'(term_r[HALF_W-1:0]) * PROD_W'(mag_r);
    end
    if (cmd.mul_hi) begin
      term_nxt = full[X_FRAC +: TERM_W];
      rem_nxt  = '0;
    end
    if (cmd.div_step) begin
      // restoring long division, several quotient bits per cycle
      for (int i = 0; i < DIV_BITS; i++) begin
        r  = {r[DVS_W-1:0], dv[TERM_W-1]};
        dv = {dv[TERM_W-2:0], 1'b0};
        if (r >= {1'b0, dvs}) begin
          r     = r - {1'b0, dvs};
          dv[0] = 1'b1;
        end
      end
      term_nxt = dv;
      rem_nxt  = r[DVS_W-1:0];
    end
    if (cmd.acc) begin
      sum_nxt = sum_r + SUM_W'(term_r);
    end
    if (cmd.out_load) begin
      if (rounded > (SUM_W-OUT_SH+1)'(OUT_MAX)) begin
        value_nxt = OUT_MAX;
        sat_nxt   = 1'b1;
      end else begin
        value_nxt = rounded[OUT_W-1:0];
        sat_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    mag_r   <= mag_nxt;
    term_r  <= term_nxt;
    sum_r   <= sum_nxt;
    plo_r   <= plo_nxt;
    rem_r   <= rem_nxt;
    value_r <= value_nxt;
    sat_r   <= sat_nxt;
  end

  assign out_cosh_value = value_r;
  assign out_saturated  = sat_r;

endmodule

[hw/rtl/cts_checker.sv]
`timescale 1ns / 1ps

module cts_checker import cts_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic [OUT_W-1:0] out_cosh_value,
  input logic             out_saturated
);

  localparam logic [OUT_W-1:0] ONE_CODE = OUT_W'(1 << OUT_SH);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_cosh_value) && $stable(out_saturated))
    else $error("stalled result changed");

  a_sat_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_cosh_value == OUT_MAX)
    else $error("saturated result not at maximum code");

  a_at_least_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_saturated |-> out_cosh_value >= ONE_CODE)
    else $error("series sum below one");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the sum finished");

endmodule

bind cosh_taylor_series cts_checker u_chk (.*);
